>>> sv/firis_pkg.sv
package firis_pkg;

    localparam int ACC_W     = 64;
    localparam int COEF_W    = 32;
    localparam int OUT_W     = 32;
    localparam int CIDX_W    = 6;
    localparam int TAPCNT_W  = 7;
    localparam int SCALE_W   = 31;
    localparam int CFG_IDX_W = 1;
    localparam int DIV_CNT_W = $clog2(ACC_W);

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEFF  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_DIVISOR = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic accept_sample;
        logic accept_coeff;
        logic mac_issue;
        logic div_start;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic last_tap;
        logic pipe_busy;
        logic out_free;
    } sts_t;

endpackage

>>> sv/fir_filter_integer_scaled.sv
// Integer direct-form FIR filter with a scaled integer coefficient table.
// Input stream: s_tuser selects the word kind (0 filter a sample, 1 write a
// coefficient); s_tdata carries sample_in, coeff_index and coeff_value.
// Output stream: one word per sample, m_tdata the filtered value and m_tuser
// the saturation flag. Coefficient words give no output word.
// Tap count and scale divisor are set through the cfg_* write port; the user
// writes them only while idle, which the block itself does not enforce.
// Each sample walks the taps with one multiply-accumulate a cycle through the
// ring and coefficient RAMs, then a restoring divider takes one quotient bit
// a cycle over the 64-bit sum. One sample is in work at a time: no new word
// is taken until its result is loaded into the output register.
// The output register holds a finished word while a new word is accepted; if
// the receiver still stalls when the next result is done, the block waits.
// Reset clears the configuration to one tap and divisor one, the ring pointer,
// and the valid bits that make both tables read as zero until written.
module fir_filter_integer_scaled #(
    parameter int MAX_TAPS    = 64,
    parameter int SAMPLE_BITS = 24,
    localparam int S_DATA_W   = ((SAMPLE_BITS + firis_pkg::CIDX_W + firis_pkg::COEF_W + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [S_DATA_W-1:0]                s_tdata,  // sample_in, coeff_index, coeff_value
    input  logic                               s_tuser,  // req_type
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [firis_pkg::OUT_W-1:0]        m_tdata,  // filtered_out
    output logic                               m_tuser,  // saturated
    input  logic                               cfg_wr_en,
    input  logic [firis_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [firis_pkg::SCALE_W-1:0]      cfg_wdata
);

    localparam int CIDX_W = firis_pkg::CIDX_W;
    localparam int COEF_W = firis_pkg::COEF_W;

    firis_pkg::cmd_t cmd;
    firis_pkg::sts_t sts;

    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [CIDX_W-1:0]             coeff_index;
    logic signed [COEF_W-1:0]      coeff_value;

    assign sample_in   = s_tdata[SAMPLE_BITS-1:0];
    assign coeff_index = s_tdata[SAMPLE_BITS +: CIDX_W];
    assign coeff_value = s_tdata[SAMPLE_BITS + CIDX_W +: COEF_W];

    firis_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_req_type (s_tuser),
        .sts        (sts),
        .s_tready   (s_tready),
        .cmd        (cmd)
    );

    firis_dp #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .sample_in    (sample_in),
        .coeff_index  (coeff_index),
        .coeff_value  (coeff_value),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .filtered_out (m_tdata),
        .saturated    (m_tuser)
    );

    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.accept_sample, cmd.accept_coeff, cmd.mac_issue,
                  cmd.div_start, cmd.div_step, cmd.out_load}))
        else $error("more than one datapath command at once");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_tvalid)
        else $error("loaded result not presented");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !sts.pipe_busy)
        else $error("accepting while multiply pipeline busy");

    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == 32'h7FFF_FFFF || m_tdata == 32'h8000_0000))
        else $error("saturation flag without limit value");

endmodule

>>> sv/firis_ram.sv
module firis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/firis_ctrl.sv
module firis_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  logic            s_req_type,
    input  firis_pkg::sts_t sts,
    output logic            s_tready,
    output firis_pkg::cmd_t cmd
);

    localparam int DIV_CNT_W = firis_pkg::DIV_CNT_W;
    localparam int ACC_W     = firis_pkg::ACC_W;

    firis_pkg::state_t      state_reg, state_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= firis_pkg::ST_IDLE;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            firis_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_req_type == firis_pkg::REQ_COEFF) begin
                        cmd.accept_coeff = 1'b1;
                    end else begin
                        cmd.accept_sample = 1'b1;
                        state_next        = firis_pkg::ST_MAC;
                    end
                end
            end
            firis_pkg::ST_MAC: begin
                cmd.mac_issue = 1'b1;
                if (sts.last_tap) begin
                    state_next = firis_pkg::ST_DRAIN;
                end
            end
            firis_pkg::ST_DRAIN: begin
                if (!sts.pipe_busy) begin
                    cmd.div_start = 1'b1;
                    div_cnt_next  = '0;
                    state_next    = firis_pkg::ST_DIV;
                end
            end
            firis_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(ACC_W - 1)) begin
                    state_next = firis_pkg::ST_OUT;
                end
            end
            firis_pkg::ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = firis_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = firis_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/firis_dp.sv
module firis_dp #(
    parameter int MAX_TAPS    = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  firis_pkg::cmd_t                      cmd,
    output firis_pkg::sts_t                      sts,
    input  logic signed [SAMPLE_BITS-1:0]        sample_in,
    input  logic [firis_pkg::CIDX_W-1:0]         coeff_index,
    input  logic signed [firis_pkg::COEF_W-1:0]  coeff_value,
    input  logic                                 cfg_wr_en,
    input  logic [firis_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [firis_pkg::SCALE_W-1:0]        cfg_wdata,
    input  logic                                 m_tready,
    output logic                                 m_tvalid,
    output logic [firis_pkg::OUT_W-1:0]          filtered_out,
    output logic                                 saturated
);

    localparam int ACC_W    = firis_pkg::ACC_W;
    localparam int COEF_W   = firis_pkg::COEF_W;
    localparam int OUT_W    = firis_pkg::OUT_W;
    localparam int SCALE_W  = firis_pkg::SCALE_W;
    localparam int TAPCNT_W = firis_pkg::TAPCNT_W;
    localparam int AW       = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int NW       = $clog2(MAX_TAPS + 1);
    localparam int PW       = SAMPLE_BITS + COEF_W;

    // configuration
    logic [TAPCNT_W-1:0] tap_count_reg;
    logic [SCALE_W-1:0]  scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg <= TAPCNT_W'(1);
            scale_reg     <= SCALE_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                firis_pkg::CFG_TAP_COUNT:     tap_count_reg <= cfg_wdata[TAPCNT_W-1:0];
                firis_pkg::CFG_SCALE_DIVISOR: scale_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [NW-1:0]      taps;
    logic [SCALE_W-1:0] divisor;

    always_comb begin
        if (tap_count_reg == '0) begin
            taps = NW'(1);
        end else if (int'(tap_count_reg) > MAX_TAPS) begin
            taps = NW'(MAX_TAPS);
        end else begin
            taps = NW'(tap_count_reg);
        end
        divisor = (scale_reg == '0) ? SCALE_W'(1) : scale_reg;
    end

    // ring pointer and tap walk
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] tap_idx_reg, tap_idx_next;
    logic [AW-1:0] wp_adv;
    logic          coeff_ok;

    always_comb begin
        wp_adv       = ((NW'(wp_reg) + NW'(1)) < taps) ? (wp_reg + 1'b1) : '0;
        wp_next      = wp_reg;
        pos_next     = pos_reg;
        tap_idx_next = tap_idx_reg;
        if (cmd.accept_sample) begin
            wp_next      = wp_adv;
            pos_next     = wp_adv;
            tap_idx_next = '0;
        end else if (cmd.mac_issue) begin
            tap_idx_next = tap_idx_reg + 1'b1;
            pos_next     = (pos_reg == '0) ? AW'(taps - NW'(1)) : (pos_reg - 1'b1);
        end
        coeff_ok = int'(coeff_index) < MAX_TAPS;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
        end else begin
            wp_reg <= wp_next;
        end
        pos_reg     <= pos_next;
        tap_idx_reg <= tap_idx_next;
    end

    // valid bits stand in for the zero reset of both tables
    logic [MAX_TAPS-1:0] ring_vld_reg, ring_vld_next;
    logic [MAX_TAPS-1:0] coef_vld_reg, coef_vld_next;

    always_comb begin
        ring_vld_next = ring_vld_reg;
        coef_vld_next = coef_vld_reg;
        if (cmd.accept_sample) begin
            ring_vld_next[wp_adv] = 1'b1;
        end
        if (cmd.accept_coeff && coeff_ok) begin
            coef_vld_next[AW'(coeff_index)] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_vld_reg <= '0;
            coef_vld_reg <= '0;
        end else begin
            ring_vld_reg <= ring_vld_next;
            coef_vld_reg <= coef_vld_next;
        end
    end

    logic [SAMPLE_BITS-1:0] ring_rdata;
    logic [COEF_W-1:0]      coef_rdata;

    firis_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_TAPS)
    ) u_ring (
        .aclk  (aclk),
        .we    (cmd.accept_sample),
        .waddr (wp_adv),
        .wdata (sample_in),
        .raddr (pos_reg),
        .rdata (ring_rdata)
    );

    firis_ram #(
        .WIDTH (COEF_W),
        .DEPTH (MAX_TAPS)
    ) u_coef (
        .aclk  (aclk),
        .we    (cmd.accept_coeff && coeff_ok),
        .waddr (AW'(coeff_index)),
        .wdata (coeff_value),
        .raddr (tap_idx_reg),
        .rdata (coef_rdata)
    );

    // multiply-accumulate pipeline
    logic                          rd_v_reg, prod_v_reg;
    logic                          ring_ok_reg, coef_ok_reg;
    logic signed [SAMPLE_BITS-1:0] a_op;
    logic signed [COEF_W-1:0]      b_op;
    logic signed [PW-1:0]          prod_reg, prod_next;
    logic [ACC_W-1:0]              acc_reg, acc_next;

    always_comb begin
        a_op      = ring_ok_reg ? $signed(ring_rdata) : '0;
        b_op      = coef_ok_reg ? $signed(coef_rdata) : '0;
        prod_next = PW'(a_op) * PW'(b_op);
        acc_next  = acc_reg;
        if (cmd.accept_sample) begin
            acc_next = '0;
        end else if (prod_v_reg) begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
        end else begin
            rd_v_reg   <= cmd.mac_issue;
            prod_v_reg <= rd_v_reg;
        end
        ring_ok_reg <= ring_vld_reg[pos_reg];
        coef_ok_reg <= coef_vld_reg[tap_idx_reg];
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
    end

    // restoring division of the magnitude, one quotient bit a cycle
    logic [ACC_W-1:0]   quo_reg, quo_next;
    logic [SCALE_W-1:0] rem_reg, rem_next;
    logic               neg_reg, neg_next;
    logic [SCALE_W:0]   rem_sh;
    logic [SCALE_W:0]   rem_sub;
    logic               rem_ge;

    always_comb begin
        rem_sh   = {rem_reg, quo_reg[ACC_W-1]};
        rem_ge   = rem_sh >= {1'b0, divisor};
        rem_sub  = rem_sh - {1'b0, divisor};
        quo_next = quo_reg;
        rem_next = rem_reg;
        neg_next = neg_reg;
        if (cmd.div_start) begin
            neg_next = acc_reg[ACC_W-1];
            quo_next = acc_reg[ACC_W-1] ? (~acc_reg + 1'b1) : acc_reg;
            rem_next = '0;
        end else if (cmd.div_step) begin
            quo_next = {quo_reg[ACC_W-2:0], rem_ge};
            rem_next = rem_ge ? rem_sub[SCALE_W-1:0] : rem_sh[SCALE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    // saturation and output register
    logic             sat;
    logic [OUT_W-1:0] res;

    always_comb begin
        if (!neg_reg) begin
            sat = |quo_reg[ACC_W-1:OUT_W-1];
            res = sat ? {1'b0, {(OUT_W-1){1'b1}}} : quo_reg[OUT_W-1:0];
        end else begin
            sat = (|quo_reg[ACC_W-1:OUT_W])
                || (quo_reg[OUT_W-1] && (|quo_reg[OUT_W-2:0]));
            res = sat ? {1'b1, {(OUT_W-1){1'b0}}} : (~quo_reg[OUT_W-1:0] + 1'b1);
        end
    end

    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0] m_data_reg;
    logic             m_sat_reg;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        if (cmd.out_load) begin
            m_data_reg <= res;
            m_sat_reg  <= sat;
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign filtered_out = m_data_reg;
    assign saturated    = m_sat_reg;

    assign sts.last_tap  = (NW'(tap_idx_reg) == (taps - NW'(1)));
    assign sts.pipe_busy = rd_v_reg || prod_v_reg;
    assign sts.out_free  = !m_tvalid_reg || m_tready;

endmodule
